// File: rtl/fpcd_pkg.sv
// Shared types and constants for the framed packet checksum deframer.
`default_nettype none
package fpcd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 4;
  localparam int unsigned STORE_BYTES   = (PAYLOAD_BYTES < 4) ? PAYLOAD_BYTES : 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Position of the end code in the shortest frame that can be good.
  localparam logic [IDX_W-1:0]  MIN_END_POS  = IDX_W'(PAYLOAD_BYTES + 4);
  localparam logic [IDX_W-1:0]  IDX_MAX      = '1;
  localparam logic [IDX_W-1:0]  POS_TYPE     = IDX_W'(1);
  localparam logic [IDX_W-1:0]  POS_LENGTH   = IDX_W'(2);
  localparam logic [IDX_W-1:0]  POS_PAYLOAD  = IDX_W'(3);
  localparam logic [BYTE_W-1:0] LENGTH_CODE  = BYTE_W'(PAYLOAD_BYTES);

  localparam logic [BYTE_W-1:0] START_CODE_RST      = 8'hAA;
  localparam logic [BYTE_W-1:0] END_CODE_RST        = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_CODE_RST       = 8'h01;
  localparam logic [BYTE_W-1:0] MARKER_INTERVAL_RST = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_CODE      = 2'd0,
    REG_END_CODE        = 2'd1,
    REG_TYPE_CODE       = 2'd2,
    REG_MARKER_INTERVAL = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [BYTE_W-1:0] start_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] type_code;
    logic [BYTE_W-1:0] marker_interval;
  } cfg_t;

  typedef struct packed {
    logic              frame_good;
    logic [WORD_W-1:0] payload_word;
    logic              send_marker;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/fpcd_if.sv
// Channel interfaces: received bytes, frame results and configuration writes.
`default_nettype none
interface fpcd_byte_if import fpcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fpcd_res_if import fpcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              frame_good;
  logic [WORD_W-1:0] payload_word;
  logic              send_marker;
  modport source (output valid, output frame_good, output payload_word,
                  output send_marker, input ready);
  modport sink   (input valid, input frame_good, input payload_word,
                  input send_marker, output ready);
endinterface

interface fpcd_cfg_if import fpcd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/fpcd_cfg_regs.sv
// Configuration register file for the deframer.
`default_nettype none
module fpcd_cfg_regs import fpcd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_valid_i,
  output logic                      wr_ready_o,
  input  wire logic [CFG_IDX_W-1:0] wr_index_i,
  input  wire logic [BYTE_W-1:0]    wr_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign wr_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_valid_i) begin
      case (wr_index_i)
        REG_START_CODE:      cfg_d.start_code      = wr_data_i;
        REG_END_CODE:        cfg_d.end_code        = wr_data_i;
        REG_TYPE_CODE:       cfg_d.type_code       = wr_data_i;
        REG_MARKER_INTERVAL: cfg_d.marker_interval = wr_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_code      <= START_CODE_RST;
      cfg_q.end_code        <= END_CODE_RST;
      cfg_q.type_code       <= TYPE_CODE_RST;
      cfg_q.marker_interval <= MARKER_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/fpcd_parser.sv
// Frame parser: per-byte state update, frame checks and the result register.
`default_nettype none
module fpcd_parser import fpcd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [BYTE_W-1:0] in_byte_i,
  output logic                   in_take_o,
  input  wire cfg_t              cfg_i,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output res_t                   res_o
);

  logic              open_q, open_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] prev_q, prev_d;
  logic              hdr_q, hdr_d;
  logic [WORD_W-1:0] store_q, store_d;
  logic [BYTE_W-1:0] count_q, count_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic              closes;
  logic              slot_free;
  logic              take;
  logic              good;
  logic [BYTE_W-1:0] body_sum;
  logic [BYTE_W-1:0] count_inc;

  assign closes    = open_q && (in_byte_i == cfg_i.end_code);
  assign slot_free = !res_valid_q || res_ready_i;
  // A byte that yields no result never waits on the output side.
  assign take      = in_valid_i && (!closes || slot_free);
  assign in_take_o = take;

  assign body_sum  = sum_q - prev_q;
  assign good      = hdr_q && (idx_q >= MIN_END_POS) && (body_sum == prev_q);
  assign count_inc = count_q + 8'd1;

  always_comb begin
    open_d      = open_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    prev_d      = prev_q;
    hdr_d       = hdr_q;
    store_d     = store_q;
    count_d     = count_q;
    res_d       = res_q;
    res_valid_d = res_valid_q && !res_ready_i;
    if (take) begin
      if (!open_q) begin
        if (in_byte_i == cfg_i.start_code) begin
          open_d  = 1'b1;
          idx_d   = POS_TYPE;
          sum_d   = '0;
          prev_d  = in_byte_i;
          hdr_d   = 1'b1;
          store_d = '0;
        end
      end else if (closes) begin
        open_d             = 1'b0;
        res_valid_d        = 1'b1;
        res_d.frame_good   = good;
        res_d.payload_word = good ? store_q : '0;
        res_d.send_marker  = 1'b0;
        if (good) begin
          if (count_inc >= cfg_i.marker_interval) begin
            count_d           = '0;
            res_d.send_marker = 1'b1;
          end else begin
            count_d = count_inc;
          end
        end
      end else begin
        if (idx_q == POS_TYPE && in_byte_i != cfg_i.type_code) begin
          hdr_d = 1'b0;
        end
        if (idx_q == POS_LENGTH && in_byte_i != LENGTH_CODE) begin
          hdr_d = 1'b0;
        end
        for (int k = 0; k < STORE_BYTES; k++) begin
          if (idx_q == POS_PAYLOAD + IDX_W'(k)) begin
            store_d[8*k +: 8] = store_q[8*k +: 8] | in_byte_i;
          end
        end
        sum_d  = sum_q + in_byte_i;
        prev_d = in_byte_i;
        if (idx_q != IDX_MAX) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      idx_q       <= '0;
      sum_q       <= '0;
      prev_q      <= '0;
      hdr_q       <= 1'b0;
      store_q     <= '0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      open_q      <= open_d;
      idx_q       <= idx_d;
      sum_q       <= sum_d;
      prev_q      <= prev_d;
      hdr_q       <= hdr_d;
      store_q     <= store_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // A frame close always shows up as a result in the next cycle.
  a_close_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && closes) |=> res_valid_q)
    else $error("closed frame did not produce a result");

  // A closing byte is never consumed while an undelivered result is stuck.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(take && closes && res_valid_q && !res_ready_i))
    else $error("result register overwritten before transfer");

  // Bad frames carry neither payload nor marker.
  a_bad_frame_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.frame_good) |-> (res_q.payload_word == '0 &&
                                            !res_q.send_marker))
    else $error("bad frame carries payload or marker");

  // An open frame always has a nonzero byte position.
  a_open_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (idx_q != '0))
    else $error("open frame with zero byte position");

endmodule
`default_nettype wire

// File: rtl/framed_packet_checksum_deframer.sv
// Top level of the framed packet checksum deframer.
//
//  channel | dir | transfer when       | carries
//  rx_i    | in  | valid && ready      | rx_byte
//  res_o   | out | valid && ready      | frame_good, payload_word, send_marker
//  cfg_i   | in  | valid && ready      | index, data (ready is always high)
//
// One byte per cycle while no closing byte waits: a byte is registered in the
// input register on transfer and updates the frame state when the parser
// takes it, with a closing byte loading the result register. The result is
// valid once the end code has passed the input and result registers.
// Reset clears the frame state, the good-frame counter and both valid flags;
// the configuration registers return to their default codes.
// While the result waits on res_o, bytes that do not close a frame keep flowing;
// only a closing byte holds in the input register until the result is taken.
`default_nettype none
module framed_packet_checksum_deframer import fpcd_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fpcd_byte_if.sink   rx_i,
  fpcd_res_if.source  res_o,
  fpcd_cfg_if.sink    cfg_i
);

  logic              in_valid_q;
  logic              in_valid_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              take;
  cfg_t              cfg;
  res_t              res;

  fpcd_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  assign rx_i.ready = !in_valid_q || take;

  always_comb begin
    in_valid_d = in_valid_q && !take;
    if (rx_i.valid && rx_i.ready) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  fpcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_q),
    .in_byte_i   (in_byte_q),
    .in_take_o   (take),
    .cfg_i       (cfg),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.frame_good   = res.frame_good;
  assign res_o.payload_word = res.payload_word;
  assign res_o.send_marker  = res.send_marker;

endmodule
`default_nettype wire
